>>> hdl/dtfm_pkg.sv
// Shared types, status codes and character constants for the decimal token parser.
package dtfm_pkg;

  localparam int unsigned WholeWidth = 23;
  localparam int unsigned FracWidth  = 10;
  localparam int unsigned ValueWidth = 32;

  // Largest whole part for which whole*1000+999 still fits in 32 bits.
  localparam logic [WholeWidth-1:0] LIMIT_CAP = 23'd4294966;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_CHAR   = 3'd1;
  localparam logic [2:0] ST_SECOND_SEP = 3'd2;
  localparam logic [2:0] ST_NO_DIGIT   = 3'd3;
  localparam logic [2:0] ST_OVERFLOW   = 3'd4;
  localparam logic [2:0] ST_SKIPPED    = 3'd5;
  localparam logic [2:0] ST_NO_TOKEN   = 3'd6;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic [2:0]            status;
    logic                  closes_line;
  } out_item_t;

  // Parser state; scaled tracks whole_acc*1000 so a close needs only one add.
  typedef struct packed {
    logic                  in_token;
    logic [WholeWidth-1:0] whole_acc;
    logic [ValueWidth-1:0] scaled;
    logic [FracWidth-1:0]  frac_acc;
    logic [1:0]            frac_count;
    logic                  digit_seen;
    logic                  in_fraction;
    logic [2:0]            token_fault;
    logic                  line_failed;
  } state_t;

  localparam state_t STATE_RESET = '{default: '0};

  function automatic logic is_gap(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

>>> hdl/dtfm_take.sv
// Per-character token update: separators, digits, faults and the overflow check.
module dtfm_take (
  input  dtfm_pkg::state_t                  cur,
  input  logic [7:0]                        char_code,
  input  logic [dtfm_pkg::WholeWidth-1:0]   limit,
  output dtfm_pkg::state_t                  taken
);

  logic [3:0]  digit;
  logic        is_sep;
  logic        is_digit;
  logic [25:0] whole_wide;
  logic [dtfm_pkg::ValueWidth-1:0] scaled_new;
  logic [dtfm_pkg::FracWidth-1:0]  frac_new;

  assign digit    = 4'(char_code - dtfm_pkg::CH_ZERO);
  assign is_sep   = (char_code == dtfm_pkg::CH_DOT) || (char_code == dtfm_pkg::CH_COMMA);
  assign is_digit = (char_code >= dtfm_pkg::CH_ZERO) && (char_code <= dtfm_pkg::CH_NINE);

  // whole*10 + d, and the matching scaled*10 + d*1000 by shift-add
  assign whole_wide = {cur.whole_acc, 3'b000} + {2'b00, cur.whole_acc, 1'b0} + 26'(digit);
  assign scaled_new = {cur.scaled[28:0], 3'b000} + {cur.scaled[30:0], 1'b0}
                    + 32'({digit, 10'b0} - {digit, 4'b0} - {digit, 3'b0});
  assign frac_new   = {cur.frac_acc[6:0], 3'b000} + {cur.frac_acc[8:0], 1'b0} + 10'(digit);

  always_comb begin
    taken = cur;
    taken.in_token = 1'b1;
    if (!cur.line_failed && cur.token_fault == dtfm_pkg::ST_OK) begin
      if (is_sep) begin
        if (cur.in_fraction) begin
          taken.token_fault = dtfm_pkg::ST_SECOND_SEP;
        end else begin
          taken.in_fraction = 1'b1;
        end
      end else if (!is_digit) begin
        taken.token_fault = dtfm_pkg::ST_BAD_CHAR;
      end else begin
        taken.digit_seen = 1'b1;
        if (cur.in_fraction) begin
          // drop digits past the third
          if (cur.frac_count != 2'd3) begin
            taken.frac_acc   = frac_new;
            taken.frac_count = cur.frac_count + 2'd1;
          end
        end else if (whole_wide > 26'(limit)) begin
          taken.token_fault = dtfm_pkg::ST_OVERFLOW;
        end else begin
          taken.whole_acc = whole_wide[dtfm_pkg::WholeWidth-1:0];
          taken.scaled    = scaled_new;
        end
      end
    end
  end

endmodule

>>> hdl/dtfm_close.sv
// Token close and line end: builds the result and the next parser state.
module dtfm_close (
  input  dtfm_pkg::state_t  cur,
  input  dtfm_pkg::state_t  taken,
  input  dtfm_pkg::in_item_t item,
  output dtfm_pkg::state_t  next,
  output dtfm_pkg::out_item_t result,
  output logic              has_result
);

  logic             gap;
  logic             closing;
  dtfm_pkg::state_t src;
  logic [dtfm_pkg::FracWidth-1:0] frac_pad;
  logic [2:0]       close_status;

  assign gap     = dtfm_pkg::is_gap(item.char_code);
  assign src     = gap ? cur : taken;
  assign closing = gap ? cur.in_token : item.line_end;

  // pad missing fraction digits with zeros
  always_comb begin
    case (src.frac_count)
      2'd0:    frac_pad = '0;
      2'd1:    frac_pad = 10'({src.frac_acc[3:0], 6'b0} + {src.frac_acc[4:0], 5'b0}
                            + {src.frac_acc[7:0], 2'b0});
      2'd2:    frac_pad = 10'({src.frac_acc[6:0], 3'b0} + {src.frac_acc[8:0], 1'b0});
      default: frac_pad = src.frac_acc;
    endcase
  end

  always_comb begin
    if (src.line_failed) begin
      close_status = dtfm_pkg::ST_SKIPPED;
    end else if (src.token_fault != dtfm_pkg::ST_OK) begin
      close_status = src.token_fault;
    end else if (!src.digit_seen) begin
      close_status = dtfm_pkg::ST_NO_DIGIT;
    end else begin
      close_status = dtfm_pkg::ST_OK;
    end
  end

  always_comb begin
    result.value       = '0;
    result.status      = dtfm_pkg::ST_OK;
    result.closes_line = item.line_end;
    has_result         = 1'b0;
    next               = gap ? cur : taken;
    if (closing) begin
      has_result    = 1'b1;
      result.status = close_status;
      if (close_status == dtfm_pkg::ST_OK) begin
        result.value = src.scaled + 32'(frac_pad);
      end
      next             = dtfm_pkg::STATE_RESET;
      next.line_failed = src.line_failed || (close_status != dtfm_pkg::ST_OK);
    end else if (gap && item.line_end) begin
      has_result    = 1'b1;
      result.status = cur.line_failed ? dtfm_pkg::ST_SKIPPED : dtfm_pkg::ST_NO_TOKEN;
    end
    if (item.line_end) begin
      next = dtfm_pkg::STATE_RESET;
    end
  end

endmodule

>>> hdl/decimal_token_to_fixed_milli.sv
// Top level: decimal token parser, one character per cycle, results times 1000.
// Path: an accepted character is held in the input register, and its result is
//   loaded into the output register when the parser advances on that character.
// Throughput: one character per cycle; the input register advances whenever the
//   output register is empty or being taken, so both sides can stream continuously.
// Reset (rst, synchronous): clears parser state and both valid flags, and sets
//   the whole-part limit to 4294966.
module decimal_token_to_fixed_milli (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [dtfm_pkg::WholeWidth-1:0] cfg_write_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dtfm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dtfm_pkg::out_item_t  out_data
);

  // Whole-part limit, clamped on write so the scaled value always fits 32 bits.
  logic [dtfm_pkg::WholeWidth-1:0] limit;

  // Input register stage.
  logic               item_valid;
  dtfm_pkg::in_item_t item;

  // Parser state and the logic around it.
  dtfm_pkg::state_t    state;
  dtfm_pkg::state_t    taken;
  dtfm_pkg::state_t    state_next;
  dtfm_pkg::out_item_t result;
  logic                has_result;
  logic                advance;

  // Advance the held character when the output register can take its result.
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= dtfm_pkg::LIMIT_CAP;
    end else if (cfg_write_en) begin
      limit <= (cfg_write_data > dtfm_pkg::LIMIT_CAP) ? dtfm_pkg::LIMIT_CAP : cfg_write_data;
    end
  end

  // Hold the incoming transaction until the parser consumes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

  dtfm_take u_take (
    .cur       (state),
    .char_code (item.char_code),
    .limit     (limit),
    .taken     (taken)
  );

  dtfm_close u_close (
    .cur        (state),
    .taken      (taken),
    .item       (item),
    .next       (state_next),
    .result     (result),
    .has_result (has_result)
  );

  // Commit the parser state once per consumed character.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtfm_pkg::STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output register: load a result when one is produced, drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= has_result;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_data <= result;
    end
  end

endmodule
